>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the UTF-8 to ASCII sanitiser.
// No dependencies; each macro clocks on i_clk and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of i_clk outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/utas_pkg.sv
// Package for the UTF-8 to ASCII sanitiser: decode phases, byte and
// character codes, and the run type passed from decoder to output stage.
package utas_pkg;

    // Decode phase codes
    typedef logic [2:0] t_phase;
    localparam t_phase PH_IDLE = 3'd0;
    localparam t_phase PH_E2A  = 3'd1;   // have 0xE2
    localparam t_phase PH_E2B  = 3'd2;   // have 0xE2 and second byte
    localparam t_phase PH_C3   = 3'd3;   // have 0xC3
    localparam t_phase PH_SKIP = 3'd4;   // dropping continuation bytes

    // Input byte codes
    localparam logic [7:0] B_LEAD_E2  = 8'hE2;
    localparam logic [7:0] B_LEAD_C3  = 8'hC3;
    localparam logic [7:0] B_GP       = 8'h80;
    localparam logic [7:0] B_ARROWS   = 8'h86;
    localparam logic [7:0] B_RARROW   = 8'h92;
    localparam logic [7:0] B_LSQUOTE  = 8'h98;
    localparam logic [7:0] B_RSQUOTE  = 8'h99;
    localparam logic [7:0] B_LDQUOTE  = 8'h9C;
    localparam logic [7:0] B_RDQUOTE  = 8'h9D;
    localparam logic [7:0] B_ENDASH   = 8'h93;
    localparam logic [7:0] B_EMDASH   = 8'h94;
    localparam logic [7:0] B_ELLIPSIS = 8'hA6;
    localparam logic [7:0] B_TIMES    = 8'h97;
    localparam logic [7:0] B_DIVIDE   = 8'hB7;

    // ASCII characters emitted
    localparam logic [6:0] CH_QUOTE  = 7'h27;
    localparam logic [6:0] CH_DQUOTE = 7'h22;
    localparam logic [6:0] CH_DASH   = 7'h2D;
    localparam logic [6:0] CH_DOT    = 7'h2E;
    localparam logic [6:0] CH_GT     = 7'h3E;
    localparam logic [6:0] CH_TILDE  = 7'h7E;
    localparam logic [6:0] CH_QMARK  = 7'h3F;
    localparam logic [6:0] CH_X      = 7'h78;
    localparam logic [6:0] CH_SLASH  = 7'h2F;

    localparam int RUN_MAX = 3;

    // Characters produced by one input item, in order
    typedef struct packed {
        logic [1:0]               num;
        logic [RUN_MAX-1:0][6:0]  chars;
    } t_run;

endpackage

>>> hdl/utf8_to_ascii_sanitiser.sv
// Top level of the UTF-8 to ASCII sanitiser: decode state, run buffer and
// handshakes. Depends on utas_pkg, utas_decode and assert_macros.svh.
//
// Takes one UTF-8 byte per item and gives zero to three ASCII characters,
// the last of each run flagged. A byte is decoded in the cycle it is
// accepted and its run is loaded into a result buffer, which presents one
// character per cycle, unless the output stalls, from the next cycle on.
// Bytes giving at most one character each stream at one byte per cycle
// while the output does not stall; a byte giving more holds the input off
// until the single run buffer has emitted them all. The next byte is taken
// in the same cycle as the last character of a run leaves.
`include "assert_macros.svh"

module utf8_to_ascii_sanitiser import utas_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_out_char,
    output logic       o_last_of_run
);

    t_run       r_run;
    logic [1:0] r_pos;
    t_phase     r_phase;
    logic [7:0] r_held;

    t_run       n_run;
    t_phase     n_phase;
    logic [7:0] n_held;

    logic in_fire;
    logic out_fire;
    logic run_done;

    // Decoder
    utas_decode u_decode (
        .i_byte  (i_in_byte),
        .i_end   (i_end_of_text),
        .i_phase (r_phase),
        .i_held  (r_held),
        .o_run   (n_run),
        .o_phase (n_phase),
        .o_held  (n_held)
    );

    // Handshakes
    assign o_out_valid   = (r_run.num != 2'd0);
    assign o_out_char    = r_run.chars[r_pos];
    assign o_last_of_run = (r_pos == r_run.num - 2'd1);
    assign out_fire      = o_out_valid && !i_out_stall;
    assign run_done      = out_fire && o_last_of_run;
    assign o_in_stall    = o_out_valid && !run_done;
    assign in_fire       = i_in_valid && !o_in_stall;

    // State and run buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= '0;
            r_pos   <= 2'd0;
            r_phase <= PH_IDLE;
            r_held  <= 8'h00;
        end else if (in_fire) begin
            r_run   <= n_run;
            r_pos   <= 2'd0;
            r_phase <= n_phase;
            r_held  <= n_held;
        end else if (run_done) begin
            r_run.num <= 2'd0;
            r_pos     <= 2'd0;
        end else if (out_fire) begin
            r_pos <= r_pos + 2'd1;
        end
    end

    // Checks
    `ASSERT_CLK(a_pos_in_run, !o_out_valid || (r_pos < r_run.num), "position beyond run")
    `ASSERT_CLK(a_take_when_free, !(in_fire && o_out_valid) || run_done, "item over busy run")
    `ASSERT_NEXT(a_end_idle, in_fire && i_end_of_text, r_phase == PH_IDLE, "not idle after end")
    `ASSERT_NEXT(a_held_stable, !in_fire, $stable(r_held), "held byte changed without an item")

endmodule

>>> hdl/utas_decode.sv
// Combinational decoder: one input byte plus the decode state gives the
// run of ASCII characters and the next state. Depends on utas_pkg.
module utas_decode import utas_pkg::*; (
    input  logic [7:0] i_byte,
    input  logic       i_end,
    input  t_phase     i_phase,
    input  logic [7:0] i_held,
    output t_run       o_run,
    output t_phase     o_phase,
    output logic [7:0] o_held
);

    logic       is_cont;
    logic       fr_emit;
    logic [6:0] fr_char;
    t_phase     fr_phase;

    assign is_cont = (i_byte[7:6] == 2'b10);

    // Byte handled from idle
    always_comb begin
        fr_emit  = 1'b1;
        fr_char  = CH_QMARK;
        fr_phase = i_end ? PH_IDLE : PH_SKIP;
        if (!i_byte[7]) begin
            fr_char  = i_byte[6:0];
            fr_phase = PH_IDLE;
        end else if (i_byte == B_LEAD_E2 && !i_end) begin
            fr_emit  = 1'b0;
            fr_phase = PH_E2A;
        end else if (i_byte == B_LEAD_C3 && !i_end) begin
            fr_emit  = 1'b0;
            fr_phase = PH_C3;
        end
    end

    // Phase dispatch
    always_comb begin
        o_run   = '0;
        o_phase = PH_IDLE;
        o_held  = i_held;
        case (i_phase)
            PH_E2A: begin
                if (i_end) begin
                    // sequence cut short; a non-continuation byte stands alone
                    o_run.chars[0] = CH_QMARK;
                    if (is_cont) begin
                        o_run.num = 2'd1;
                    end else begin
                        o_run.num      = 2'd2;
                        o_run.chars[1] = fr_char;
                    end
                end else begin
                    o_held  = i_byte;
                    o_phase = PH_E2B;
                end
            end
            PH_E2B: begin
                o_run.num      = 2'd1;
                o_run.chars[0] = CH_TILDE;
                if (i_held == B_GP && (i_byte == B_LSQUOTE || i_byte == B_RSQUOTE)) begin
                    o_run.chars[0] = CH_QUOTE;
                end else if (i_held == B_GP
                             && (i_byte == B_LDQUOTE || i_byte == B_RDQUOTE)) begin
                    o_run.chars[0] = CH_DQUOTE;
                end else if (i_held == B_GP
                             && (i_byte == B_ENDASH || i_byte == B_EMDASH)) begin
                    o_run.chars[0] = CH_DASH;
                end else if (i_held == B_GP && i_byte == B_ELLIPSIS) begin
                    o_run.num   = 2'd3;
                    o_run.chars = {CH_DOT, CH_DOT, CH_DOT};
                end else if (i_held == B_ARROWS && i_byte == B_RARROW) begin
                    o_run.num      = 2'd2;
                    o_run.chars[0] = CH_DASH;
                    o_run.chars[1] = CH_GT;
                end
            end
            PH_C3: begin
                o_run.num      = 2'd1;
                o_run.chars[0] = CH_QMARK;
                if (i_byte == B_TIMES) begin
                    o_run.chars[0] = CH_X;
                end else if (i_byte == B_DIVIDE) begin
                    o_run.chars[0] = CH_SLASH;
                end
            end
            PH_SKIP: begin
                if (is_cont) begin
                    o_phase = PH_SKIP;
                end else begin
                    o_run.num      = {1'b0, fr_emit};
                    o_run.chars[0] = fr_char;
                    o_phase        = fr_phase;
                end
            end
            default: begin
                o_run.num      = {1'b0, fr_emit};
                o_run.chars[0] = fr_char;
                o_phase        = fr_phase;
            end
        endcase
        // end of text always returns to idle
        if (i_end) begin
            o_phase = PH_IDLE;
        end
    end

endmodule

>>> sim/utas_stream_checker.sv
// Stream checker for the UTF-8 to ASCII sanitiser: watches both channels,
// predicts the characters of every accepted byte and compares them in order.
// Depends on utas_pkg for the decode phases and character codes.
`timescale 1ns / 100ps

module utas_stream_checker import utas_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [6:0] i_out_char,
    input  logic       i_last_of_run,
    input  logic       i_end_check,
    output int         o_fails,
    output int         o_pending
);

    // Continuation bytes are 10xxxxxx
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_expected_char;

    // Predicted decoder state
    t_phase     phase;
    logic [7:0] held_b1;

    // Characters of the byte being predicted
    logic [6:0] run_buf [RUN_MAX];
    int         run_len;

    t_expected_char expected_chars[$];
    bit             end_checked;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fails++;
    endtask

    function automatic bit is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    task automatic add_char(input logic [6:0] ch);
        if (run_len < RUN_MAX) begin
            run_buf[run_len] = ch;
            run_len++;
        end
    endtask

    // Byte seen with no sequence open
    task automatic take_fresh(input logic [7:0] b, input logic eot);
        if (b < 8'h80) begin
            add_char(b[6:0]);
            phase = PH_IDLE;
        end else if (b == B_LEAD_E2 && !eot) begin
            phase = PH_E2A;
        end else if (b == B_LEAD_C3 && !eot) begin
            phase = PH_C3;
        end else begin
            add_char(CH_QMARK);
            phase = eot ? PH_IDLE : PH_SKIP;
        end
    endtask

    // Three-byte punctuation after 0xE2
    task automatic map_triple(input logic [7:0] b1, input logic [7:0] b2);
        if (b1 == B_GP && (b2 == B_LSQUOTE || b2 == B_RSQUOTE)) begin
            add_char(CH_QUOTE);
        end else if (b1 == B_GP && (b2 == B_LDQUOTE || b2 == B_RDQUOTE)) begin
            add_char(CH_DQUOTE);
        end else if (b1 == B_GP && (b2 == B_ENDASH || b2 == B_EMDASH)) begin
            add_char(CH_DASH);
        end else if (b1 == B_GP && b2 == B_ELLIPSIS) begin
            add_char(CH_DOT);
            add_char(CH_DOT);
            add_char(CH_DOT);
        end else if (b1 == B_ARROWS && b2 == B_RARROW) begin
            add_char(CH_DASH);
            add_char(CH_GT);
        end else begin
            add_char(CH_TILDE);
        end
    endtask

    // Predict the run of one accepted byte and queue it
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        t_expected_char item;
        run_len = 0;
        case (phase)
            PH_E2A: begin
                if (eot) begin
                    add_char(CH_QMARK);
                    phase = PH_IDLE;
                    if (!is_cont(b)) take_fresh(b, 1'b1);
                end else begin
                    held_b1 = b;
                    phase   = PH_E2B;
                end
            end
            PH_E2B: begin
                map_triple(held_b1, b);
                phase = PH_IDLE;
            end
            PH_C3: begin
                if (b == B_TIMES)       add_char(CH_X);
                else if (b == B_DIVIDE) add_char(CH_SLASH);
                else                    add_char(CH_QMARK);
                phase = PH_IDLE;
            end
            PH_SKIP: begin
                if (is_cont(b)) phase = eot ? PH_IDLE : PH_SKIP;
                else            take_fresh(b, eot);
            end
            default: take_fresh(b, eot);
        endcase
        if (eot) phase = PH_IDLE;
        for (int k = 0; k < run_len; k++) begin
            item.ch   = run_buf[k];
            item.last = (k == run_len - 1);
            expected_chars.insert(expected_chars.size(), item);
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_expected_char want;
        if (!i_rst_n) begin
            phase       = PH_IDLE;
            held_b1     = '0;
            run_len     = 0;
            end_checked = 1'b0;
            expected_chars.delete();
        end else begin
            if (i_in_valid && !i_in_stall) decode_byte(i_in_byte, i_end_of_text);
            if (i_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character %02h last %0b",
                                              i_out_char, i_last_of_run));
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_char !== want.ch)
                        report_mismatch($sformatf("character %02h, expected %02h",
                                                  i_out_char, want.ch));
                    if (i_last_of_run !== want.last)
                        report_mismatch($sformatf("last flag %0b, expected %0b on %02h",
                                                  i_last_of_run, want.last, want.ch));
                end
            end
            if (i_end_check && !end_checked) begin
                end_checked = 1'b1;
                while (expected_chars.size() != 0) begin
                    want = expected_chars.pop_front();
                    report_mismatch($sformatf("character %02h never arrived", want.ch));
                end
            end
        end
        o_pending = expected_chars.size();
    end

endmodule

>>> sim/tb.sv
// Testbench top for the UTF-8 to ASCII sanitiser: clock, reset, byte stimulus
// and output stall pattern. Depends on utas_pkg, utas_stream_checker and the RTL.
`timescale 1ns / 100ps

module tb;
    import utas_pkg::*;

    localparam int RANDOM_BYTES = 330;
    localparam int TAIL_CYCLES  = 10;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_end_of_text;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [6:0] o_out_char;
    logic       o_last_of_run;
    logic       end_check;
    int         fail_count;
    int         pending_chars;

    int burst_left = 0;
    int bytes_sent = 0;

    utf8_to_ascii_sanitiser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run)
    );

    utas_stream_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_char    (o_out_char),
        .i_last_of_run (o_last_of_run),
        .i_end_check   (end_check),
        .o_fails       (fail_count),
        .o_pending     (pending_chars)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Offer one byte at a falling edge, bursts sometimes separated by random gaps
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    = 1'b1;
        i_in_byte     = b;
        i_end_of_text = eot;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Hold the sender off until every predicted character has left
    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (pending_chars != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // 0xE2 sequence, mostly known punctuation, sometimes cut by end of text
    task automatic send_e2(input logic close);
        logic [7:0] b1;
        logic [7:0] b2;
        int         pick;
        int         cut;
        pick = $urandom_range(0, 9);
        b1   = B_GP;
        case (pick)
            0: b2 = B_LSQUOTE;
            1: b2 = B_RSQUOTE;
            2: b2 = B_LDQUOTE;
            3: b2 = B_RDQUOTE;
            4: b2 = B_ENDASH;
            5: b2 = B_EMDASH;
            6: b2 = B_ELLIPSIS;
            7: begin
                b1 = B_ARROWS;
                b2 = B_RARROW;
            end
            8: begin
                b1 = ($urandom_range(0, 1) == 0) ? B_ARROWS : B_GP;
                b2 = cont_byte();
            end
            default: begin
                b1 = 8'($urandom_range(0, 255));
                b2 = 8'($urandom_range(0, 255));
            end
        endcase
        cut = $urandom_range(0, 9);
        if (cut == 0) begin
            send_byte(B_LEAD_E2, 1'b1);
        end else if (cut == 1) begin
            send_byte(B_LEAD_E2, 1'b0);
            send_byte(($urandom_range(0, 1) == 0) ? b1 : 8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_byte(B_LEAD_E2, 1'b0);
            send_byte(b1, 1'b0);
            send_byte(b2, close);
        end
    endtask

    // 0xC3 sequence: times, divide or anything else
    task automatic send_c3(input logic close);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            send_byte(B_LEAD_C3, 1'b1);
        end else begin
            send_byte(B_LEAD_C3, 1'b0);
            if (pick < 4)      send_byte(B_TIMES, close);
            else if (pick < 7) send_byte(B_DIVIDE, close);
            else               send_byte(8'($urandom_range(0, 255)), close);
        end
    endtask

    // Output stall: patterns of random length, including stretches with none
    initial begin
        t_stall_mode mode;
        int          span;
        int          tick;
        i_out_stall = 1'b0;
        tick        = 0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 120);
            repeat (span) begin
                @(negedge i_clk);
                tick++;
                case (mode)
                    STALL_NONE:     i_out_stall = 1'b0;
                    STALL_LIGHT:    i_out_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    i_out_stall = ($urandom_range(0, 9) < 7);
                    STALL_PERIODIC: i_out_stall = (tick % 4 == 3);
                    default:        i_out_stall = 1'b0;
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int   pick;
        int   hops;
        logic close;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_byte     = '0;
        i_end_of_text = 1'b0;
        end_check     = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: ASCII extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // ellipsis gives the longest run, of three characters, and arrow a run of two
        send_byte(B_LEAD_E2, 1'b0);
        send_byte(B_GP, 1'b0);
        send_byte(B_ELLIPSIS, 1'b0);
        send_byte(B_LEAD_E2, 1'b0);
        send_byte(B_ARROWS, 1'b0);
        send_byte(B_RARROW, 1'b0);
        // unknown 0xE2 pair with non-continuation bytes
        send_byte(B_LEAD_E2, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(B_LEAD_C3, 1'b0);
        send_byte(B_TIMES, 1'b0);
        // lead byte at end of text
        send_byte(B_LEAD_C3, 1'b1);
        // 0xE2 cut after one byte: continuation, ASCII, high byte
        send_byte(B_LEAD_E2, 1'b0);
        send_byte(8'h85, 1'b1);
        send_byte(B_LEAD_E2, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(B_LEAD_E2, 1'b0);
        send_byte(8'hF0, 1'b1);
        // stray continuation, dropped continuation, then ASCII ends dropping
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h41, 1'b0);
        // dropping ended by end of text
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_drain();

        // Random text: mostly well-formed sequences, some noise
        while (bytes_sent < RANDOM_BYTES) begin
            pick  = $urandom_range(0, 99);
            close = ($urandom_range(0, 9) == 0);
            if (pick < 40) begin
                send_byte(8'($urandom_range(0, 127)), close);
            end else if (pick < 65) begin
                send_e2(close);
            end else if (pick < 80) begin
                send_c3(close);
            end else if (pick < 90) begin
                hops = $urandom_range(0, 3);
                send_byte(8'($urandom_range(128, 255)), close && hops == 0);
                for (int k = 0; k < hops; k++)
                    send_byte(cont_byte(), close && k == hops - 1);
            end else begin
                send_byte(8'($urandom_range(0, 255)), close);
            end
            if (close && $urandom_range(0, 3) == 0) wait_drain();
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        end_check = 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
